// ----- hdl/cts_pkg.sv -----
// Shared types, codes and saturating fixed-point helpers for the cyclic
// tridiagonal solver. No dependencies.
package cts_pkg;

    typedef logic signed [31:0] t_fx;

    typedef struct packed {
        t_fx  sub_diag;
        t_fx  main_diag;
        t_fx  super_diag;
        t_fx  rhs_value;
        logic last_row;
    } t_row_in;

    typedef struct packed {
        t_fx        solution;
        logic       last_value;
        logic [1:0] status;
    } t_result;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_ROWS = 2'd2;

    localparam t_fx FX_MAX = 32'sh7fffffff;
    localparam t_fx FX_MIN = 32'sh80000000;

    typedef enum logic [4:0] {
        ACT_NONE, ACT_CAP0, ACT_MD0, ACT_CAPN, ACT_MUL_AB, ACT_DIV_MG, ACT_MDN,
        ACT_F0, ACT_DIV_SUB, ACT_MUL_MSUP, ACT_ED_MER, ACT_ER, ACT_DIV_X, ACT_XN,
        ACT_MUL_SX, ACT_T, ACT_DIV_T, ACT_MUL_BSOL, ACT_NUMP_BCOR, ACT_DENP,
        ACT_NUMDEN, ACT_DIV_F, ACT_FACT, ACT_MUL_FC, ACT_EMIT_PLAIN, ACT_EMIT_CYC
    } t_act;

    typedef struct packed {
        t_act act;
        logic first;
        logic last;
        logic cyc;
        logic pass2;
        logic we_row;
        logic we_elim;
        logic we_sol;
        logic we_cor;
        logic drop;
        logic emit_last;
    } t_cmd;

    function automatic t_fx sat_add(t_fx a, t_fx b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? FX_MIN : FX_MAX;
        end
        return s[31:0];
    endfunction

    function automatic t_fx sat_sub(t_fx a, t_fx b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? FX_MIN : FX_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic [31:0] mag32(t_fx v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

    function automatic t_fx sat_mag(logic neg, logic [63:0] m);
        logic [31:0] lo;
        lo = m[31:0];
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
                return FX_MIN;
            end
            return $signed(~lo + 32'd1);
        end
        if (m > 64'h0000_0000_7fff_ffff) begin
            return FX_MAX;
        end
        return $signed(lo);
    endfunction

endpackage

// ----- hdl/cyclic_tridiagonal_solver.sv -----
// Top level of the cyclic tridiagonal solver.
// Depends on cts_pkg, cts_ctrl and cts_dp.
//
// Rows load one per cycle while busy is low; the row with last_row set starts
// the solve, and busy stays high until the cycle that shows the last result word.
// Results appear one per strobe on o_valid for a single cycle each and cannot
// be held off. The mode register takes a write only while busy is low. Every
// division goes through one shared bit-serial divider, and it sets the pace: a
// cyclic solve runs the elimination and back substitution twice and adds the
// corner and correction terms, and the output words follow. Rows past
// MAX_POINTS are dropped and reported in the status of every result word.
module cyclic_tridiagonal_solver #(
    parameter int MAX_POINTS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  cts_pkg::t_row_in     i_row,
    output logic                 busy,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_data,
    output logic                 o_cfg_ready,
    output logic                 o_valid,
    output cts_pkg::t_result     o_result
);
    cts_pkg::t_cmd                 cmd;
    logic [$clog2(MAX_POINTS)-1:0] addr;
    logic                          div_busy;

    cts_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_last_row(i_row.last_row), .o_busy(busy),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .i_div_busy(div_busy), .o_cmd(cmd), .o_addr(addr)
    );

    cts_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_addr(addr),
        .i_row(i_row), .o_div_busy(div_busy), .o_valid(o_valid), .o_result(o_result)
    );

    assign o_cfg_ready = !busy;
endmodule

// ----- hdl/cts_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module cts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/cts_div.sv -----
// Iterative rounded fixed-point divider, one quotient bit per cycle.
// Depends on cts_pkg.
module cts_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cts_pkg::t_fx  i_num,
    input  cts_pkg::t_fx  i_den,
    output logic          o_busy,
    output cts_pkg::t_fx  o_quo
);
    localparam int DivW = 33 + FRAC_BITS;
    localparam int CntW = $clog2(DivW + 1);

    logic [DivW-1:0] r_a;
    logic [32:0]     r_rem;
    logic [31:0]     r_dm;
    logic            r_neg;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    cts_pkg::t_fx    r_quo;

    logic [32:0]     n_rem_sh;
    logic            n_ge;
    logic [DivW-1:0] n_a;
    logic [DivW-1:0] n_load;

    always_comb begin
        n_rem_sh = {r_rem[31:0], r_a[DivW-1]};
        n_ge     = n_rem_sh >= {1'b0, r_dm};
        n_a      = {r_a[DivW-2:0], n_ge};
        n_load   = {1'b0, cts_pkg::mag32(i_num), {FRAC_BITS{1'b0}}}
                 + DivW'(cts_pkg::mag32(i_den) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            if (i_den == '0) begin
                r_quo <= i_num[31] ? cts_pkg::FX_MIN : cts_pkg::FX_MAX;
            end else begin
                r_a    <= n_load;
                r_rem  <= '0;
                r_dm   <= cts_pkg::mag32(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
                r_cnt  <= CntW'(DivW);
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_rem_sh - {1'b0, r_dm}) : n_rem_sh;
            r_a   <= n_a;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
                r_quo  <= cts_pkg::sat_mag(r_neg, 64'(n_a));
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ----- hdl/cts_dp.sv -----
// Solver datapath: row and work memories, multiplier, divider, scalars.
// Depends on cts_pkg, cts_ram and cts_div.
module cts_dp #(
    parameter int MAX_POINTS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cts_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_addr,
    input  cts_pkg::t_row_in              i_row,
    output logic                          o_div_busy,
    output logic                          o_valid,
    output cts_pkg::t_result              o_result
);
    localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);
    localparam cts_pkg::t_fx One = 32'sd1 <<< FRAC_BITS;

    logic [127:0] row_rd;
    logic [63:0]  elim_rd;
    logic [31:0]  sol_rd, cor_rd;
    cts_pkg::t_fx rd_sub, rd_diag, rd_sup, rd_rhs, rd_ed, rd_er, rd_sol, rd_cor;

    cts_pkg::t_fx r_beta, r_alpha, r_gamma, r_md0, r_mdn, r_ed_prev, r_er_prev;
    cts_pkg::t_fx r_sup_prev, r_xnext, r_fact, r_t, r_m;
    logic [63:0]  r_pm;
    logic         r_pneg;
    logic [1:0]   r_err;
    logic         r_valid;
    cts_pkg::t_result r_res;

    cts_pkg::t_fx dg, rs, mul_a, mul_b, mul_res, div_n, div_d, quo;
    logic         div_go;
    logic [63:0]  pm_rnd;

    cts_ram #(.WIDTH(128), .DEPTH(MAX_POINTS)) u_row (
        .i_clk(i_clk), .i_we(i_cmd.we_row), .i_addr(i_addr),
        .i_wdata({i_row.sub_diag, i_row.main_diag, i_row.super_diag, i_row.rhs_value}),
        .o_rdata(row_rd)
    );
    cts_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_elim (
        .i_clk(i_clk), .i_we(i_cmd.we_elim), .i_addr(i_addr),
        .i_wdata({r_ed_prev, r_er_prev}), .o_rdata(elim_rd)
    );
    cts_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_sol (
        .i_clk(i_clk), .i_we(i_cmd.we_sol), .i_addr(i_addr),
        .i_wdata(quo), .o_rdata(sol_rd)
    );
    cts_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_cor (
        .i_clk(i_clk), .i_we(i_cmd.we_cor), .i_addr(i_addr),
        .i_wdata(quo), .o_rdata(cor_rd)
    );

    cts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_num(div_n), .i_den(div_d), .o_busy(o_div_busy), .o_quo(quo)
    );

    always_comb begin
        rd_sub  = $signed(row_rd[127:96]);
        rd_diag = $signed(row_rd[95:64]);
        rd_sup  = $signed(row_rd[63:32]);
        rd_rhs  = $signed(row_rd[31:0]);
        rd_ed   = $signed(elim_rd[63:32]);
        rd_er   = $signed(elim_rd[31:0]);
        rd_sol  = $signed(sol_rd);
        rd_cor  = $signed(cor_rd);

        if (i_cmd.cyc && i_cmd.last) begin
            dg = r_mdn;
        end else if (i_cmd.cyc && i_cmd.first) begin
            dg = r_md0;
        end else begin
            dg = rd_diag;
        end

        if (!i_cmd.pass2) begin
            rs = rd_rhs;
        end else if (i_cmd.last) begin
            rs = r_alpha;
        end else if (i_cmd.first) begin
            rs = r_gamma;
        end else begin
            rs = '0;
        end

        pm_rnd  = (r_pm + Half) >> FRAC_BITS;
        mul_res = cts_pkg::sat_mag(r_pneg, pm_rnd);

        mul_a = r_alpha;
        mul_b = r_beta;
        unique case (i_cmd.act)
            cts_pkg::ACT_MUL_MSUP:  begin mul_a = quo;     mul_b = r_sup_prev; end
            cts_pkg::ACT_ED_MER:    begin mul_a = quo;     mul_b = r_er_prev;  end
            cts_pkg::ACT_MUL_SX:    begin mul_a = rd_sup;  mul_b = r_xnext;    end
            cts_pkg::ACT_MUL_BSOL:  begin mul_a = r_beta;  mul_b = rd_sol;     end
            cts_pkg::ACT_NUMP_BCOR: begin mul_a = r_beta;  mul_b = rd_cor;     end
            cts_pkg::ACT_MUL_FC:    begin mul_a = r_fact;  mul_b = rd_cor;     end
            default:                begin mul_a = r_alpha; mul_b = r_beta;     end
        endcase

        div_go = 1'b1;
        div_n  = mul_res;
        div_d  = r_gamma;
        unique case (i_cmd.act)
            cts_pkg::ACT_DIV_MG:  begin div_n = mul_res;   div_d = r_gamma;   end
            cts_pkg::ACT_DIV_SUB: begin div_n = rd_sub;    div_d = r_ed_prev; end
            cts_pkg::ACT_DIV_X:   begin div_n = r_er_prev; div_d = r_ed_prev; end
            cts_pkg::ACT_DIV_T:   begin div_n = r_t;       div_d = rd_ed;     end
            cts_pkg::ACT_DIV_F:   begin div_n = r_t;       div_d = r_m;       end
            default:              div_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pm   <= cts_pkg::mag32(mul_a) * cts_pkg::mag32(mul_b);
        r_pneg <= mul_a[31] ^ mul_b[31];
        unique case (i_cmd.act)
            cts_pkg::ACT_CAP0: begin
                r_beta  <= rd_sub;
                r_gamma <= cts_pkg::sat_sub('0, rd_diag);
                r_t     <= rd_diag;
            end
            cts_pkg::ACT_MD0:  r_md0 <= cts_pkg::sat_sub(r_t, r_gamma);
            cts_pkg::ACT_CAPN: begin
                r_alpha <= rd_sup;
                r_t     <= i_cmd.first ? r_md0 : rd_diag;
            end
            cts_pkg::ACT_MDN:  r_mdn <= cts_pkg::sat_sub(r_t, quo);
            cts_pkg::ACT_F0: begin
                r_ed_prev  <= dg;
                r_er_prev  <= rs;
                r_sup_prev <= rd_sup;
            end
            cts_pkg::ACT_ED_MER: r_ed_prev <= cts_pkg::sat_sub(dg, mul_res);
            cts_pkg::ACT_ER: begin
                r_er_prev  <= cts_pkg::sat_sub(rs, mul_res);
                r_sup_prev <= rd_sup;
            end
            cts_pkg::ACT_XN:        r_xnext <= quo;
            cts_pkg::ACT_T:         r_t <= cts_pkg::sat_sub(rd_er, mul_res);
            cts_pkg::ACT_NUMP_BCOR: r_t <= quo;
            cts_pkg::ACT_DENP:      r_m <= quo;
            cts_pkg::ACT_NUMDEN: begin
                r_t <= cts_pkg::sat_add(rd_sol, r_t);
                r_m <= cts_pkg::sat_add(cts_pkg::sat_add(One, rd_cor), r_m);
            end
            cts_pkg::ACT_FACT: r_fact <= quo;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.act == cts_pkg::ACT_EMIT_PLAIN)
                    || (i_cmd.act == cts_pkg::ACT_EMIT_CYC);
            if (i_cmd.emit_last) begin
                r_err <= '0;
            end else begin
                if (i_cmd.drop) begin
                    r_err[1] <= 1'b1;
                end
                if (div_go && div_d == '0) begin
                    r_err[0] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.solution   <= (i_cmd.act == cts_pkg::ACT_EMIT_CYC)
                          ? cts_pkg::sat_sub(rd_sol, mul_res) : rd_sol;
        r_res.last_value <= i_cmd.emit_last;
        r_res.status     <= r_err[1] ? cts_pkg::STATUS_ROWS
                          : (r_err[0] ? cts_pkg::STATUS_ZERO : cts_pkg::STATUS_OK);
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;
endmodule

// ----- hdl/cts_ctrl.sv -----
// Solver sequencer: row loading, one elimination pass (two and a correction in cyclic mode), output.
// Depends on cts_pkg.
module cts_ctrl #(
    parameter int MAX_POINTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_last_row,
    output logic                          o_busy,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_data,
    input  logic                          i_div_busy,
    output cts_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_addr
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int JW = $clog2(MAX_POINTS + 2);
    localparam int NS = 35;

    typedef enum logic [NS-1:0] {
        S_IDLE = NS'(1) << 0,  S_RD = NS'(1) << 1,   S_DW = NS'(1) << 2,
        S_C0   = NS'(1) << 3,  S_C1 = NS'(1) << 4,   S_C2 = NS'(1) << 5,
        S_C3   = NS'(1) << 6,  S_C4 = NS'(1) << 7,   S_C5 = NS'(1) << 8,
        S_C6   = NS'(1) << 9,  S_T0 = NS'(1) << 10,  S_T1 = NS'(1) << 11,
        S_T2   = NS'(1) << 12, S_T3 = NS'(1) << 13,  S_T4 = NS'(1) << 14,
        S_T5   = NS'(1) << 15, S_T6 = NS'(1) << 16,  S_T7 = NS'(1) << 17,
        S_B0   = NS'(1) << 18, S_B1 = NS'(1) << 19,  S_B2 = NS'(1) << 20,
        S_B3   = NS'(1) << 21, S_B4 = NS'(1) << 22,  S_F0 = NS'(1) << 23,
        S_F1   = NS'(1) << 24, S_F2 = NS'(1) << 25,  S_F3 = NS'(1) << 26,
        S_F4   = NS'(1) << 27, S_F5 = NS'(1) << 28,  S_F6 = NS'(1) << 29,
        S_F7   = NS'(1) << 30, S_F8 = NS'(1) << 31,  S_O0 = NS'(1) << 32,
        S_O1   = NS'(1) << 33, S_O2 = NS'(1) << 34
    } t_state;

    t_state        r_state, n_state, r_ret, n_ret;
    logic [AW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_count, n_count, r_n, n_n;
    logic [JW-1:0] r_j, n_j;
    logic          r_pass2, n_pass2, r_cyc, n_cyc;

    logic [AW-1:0] last_idx, out_addr;
    logic [JW-1:0] j_end;
    logic          j_last, room;
    cts_pkg::t_cmd cmd;

    always_comb begin
        last_idx = AW'(r_n - 1'b1);
        j_end    = r_cyc ? (JW'(r_n) + 1'b1) : (JW'(r_n) - 1'b1);
        j_last   = r_j == j_end;
        room     = r_count < CW'(MAX_POINTS);
        if (!r_cyc) begin
            out_addr = AW'(r_j);
        end else if (r_j == '0) begin
            out_addr = last_idx;
        end else if (r_j == j_end) begin
            out_addr = '0;
        end else begin
            out_addr = AW'(r_j - 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_addr  = r_addr;
        n_count = r_count;
        n_n     = r_n;
        n_j     = r_j;
        n_pass2 = r_pass2;
        n_cyc   = r_cyc;
        cmd       = '0;
        cmd.act   = cts_pkg::ACT_NONE;
        cmd.cyc   = r_cyc;
        cmd.pass2 = r_pass2;
        cmd.first = r_addr == '0;
        cmd.last  = r_addr == last_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_cyc = i_cfg_data;
                end
                if (i_start) begin
                    if (room) begin
                        cmd.we_row = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        cmd.drop = 1'b1;
                    end
                    if (i_last_row) begin
                        n_n     = room ? (r_count + 1'b1) : r_count;
                        n_pass2 = 1'b0;
                        n_state = n_cyc ? S_C0 : S_T0;
                    end
                end
            end
            S_RD: n_state = r_ret;
            S_DW: begin
                if (!i_div_busy) begin
                    n_state = r_ret;
                end
            end
            S_C0: begin n_addr = '0; n_ret = S_C1; n_state = S_RD; end
            S_C1: begin cmd.act = cts_pkg::ACT_CAP0; n_state = S_C2; end
            S_C2: begin
                cmd.act = cts_pkg::ACT_MD0;
                n_addr  = last_idx;
                n_ret   = S_C3;
                n_state = S_RD;
            end
            S_C3: begin cmd.act = cts_pkg::ACT_CAPN;   n_state = S_C4; end
            S_C4: begin cmd.act = cts_pkg::ACT_MUL_AB; n_state = S_C5; end
            S_C5: begin cmd.act = cts_pkg::ACT_DIV_MG; n_ret = S_C6; n_state = S_DW; end
            S_C6: begin cmd.act = cts_pkg::ACT_MDN;    n_state = S_T0; end
            S_T0: begin n_addr = '0; n_ret = S_T1; n_state = S_RD; end
            S_T1: begin cmd.act = cts_pkg::ACT_F0; n_state = S_T2; end
            S_T2, S_T7: begin
                cmd.we_elim = 1'b1;
                if (r_addr == last_idx) begin
                    n_state = S_B0;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_ret   = S_T3;
                    n_state = S_RD;
                end
            end
            S_T3: begin cmd.act = cts_pkg::ACT_DIV_SUB; n_ret = S_T4; n_state = S_DW; end
            S_T4: begin cmd.act = cts_pkg::ACT_MUL_MSUP; n_state = S_T5; end
            S_T5: begin cmd.act = cts_pkg::ACT_ED_MER;   n_state = S_T6; end
            S_T6: begin cmd.act = cts_pkg::ACT_ER;       n_state = S_T7; end
            S_B0: begin cmd.act = cts_pkg::ACT_DIV_X; n_ret = S_B1; n_state = S_DW; end
            S_B1: begin
                cmd.act    = cts_pkg::ACT_XN;
                cmd.we_sol = !r_pass2;
                cmd.we_cor = r_pass2;
                if (r_addr != '0) begin
                    n_addr  = r_addr - 1'b1;
                    n_ret   = S_B2;
                    n_state = S_RD;
                end else if (r_cyc && !r_pass2) begin
                    n_pass2 = 1'b1;
                    n_state = S_T0;
                end else if (r_cyc) begin
                    n_state = S_F0;
                end else begin
                    n_j     = '0;
                    n_state = S_O0;
                end
            end
            S_B2: begin cmd.act = cts_pkg::ACT_MUL_SX; n_state = S_B3; end
            S_B3: begin cmd.act = cts_pkg::ACT_T;      n_state = S_B4; end
            S_B4: begin cmd.act = cts_pkg::ACT_DIV_T; n_ret = S_B1; n_state = S_DW; end
            S_F0: begin n_addr = last_idx; n_ret = S_F1; n_state = S_RD; end
            S_F1: begin cmd.act = cts_pkg::ACT_MUL_BSOL; n_state = S_F2; end
            S_F2: begin cmd.act = cts_pkg::ACT_DIV_MG; n_ret = S_F3; n_state = S_DW; end
            S_F3: begin cmd.act = cts_pkg::ACT_NUMP_BCOR; n_state = S_F4; end
            S_F4: begin cmd.act = cts_pkg::ACT_DIV_MG; n_ret = S_F5; n_state = S_DW; end
            S_F5: begin
                cmd.act = cts_pkg::ACT_DENP;
                n_addr  = '0;
                n_ret   = S_F6;
                n_state = S_RD;
            end
            S_F6: begin cmd.act = cts_pkg::ACT_NUMDEN; n_state = S_F7; end
            S_F7: begin cmd.act = cts_pkg::ACT_DIV_F; n_ret = S_F8; n_state = S_DW; end
            S_F8: begin cmd.act = cts_pkg::ACT_FACT; n_j = '0; n_state = S_O0; end
            S_O0: begin n_addr = out_addr; n_ret = S_O1; n_state = S_RD; end
            S_O1, S_O2: begin
                if (r_state == S_O1 && r_cyc) begin
                    cmd.act = cts_pkg::ACT_MUL_FC;
                    n_state = S_O2;
                end else begin
                    cmd.act       = r_cyc ? cts_pkg::ACT_EMIT_CYC : cts_pkg::ACT_EMIT_PLAIN;
                    cmd.emit_last = j_last;
                    if (j_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_O0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_count <= '0;
            r_cyc   <= 1'b1;
            r_pass2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_cyc   <= n_cyc;
            r_pass2 <= n_pass2;
        end
        r_addr <= n_addr;
        r_n    <= n_n;
        r_j    <= n_j;
    end

    assign o_cmd  = cmd;
    assign o_addr = (r_state == S_IDLE) ? AW'(r_count) : r_addr;
    assign o_busy = r_state != S_IDLE;
endmodule

// ----- dv/tb_cyclic_tridiagonal_solver.sv -----
// Self-checking testbench for cyclic_tridiagonal_solver: loads row systems in
// plain and periodic mode and checks every result word against a Q16.16 predictor.
// Depends on cts_pkg and the solver RTL.
module tb_cyclic_tridiagonal_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ROWS_MAX   = 32;
    localparam int  FRAC       = 16;
    localparam int  CYCLE_CAP  = 2000000;
    localparam longint VMAX    = 64'sd2147483647;
    localparam longint VMIN    = -64'sd2147483648;
    localparam longint ONE_FX  = 64'sd1 <<< FRAC;
    localparam bit  MODE_PLAIN = 1'b0;
    localparam bit  MODE_CYC   = 1'b1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    cts_pkg::t_row_in  i_row = '0;
    logic              busy;
    logic              i_cfg_valid = 1'b0;
    logic              i_cfg_data = 1'b0;
    logic              o_cfg_ready;
    logic              o_valid;
    cts_pkg::t_result  o_result;

    cyclic_tridiagonal_solver #(.MAX_POINTS(ROWS_MAX), .FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_row(i_row), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready),
        .o_valid(o_valid), .o_result(o_result)
    );

    cts_pkg::t_row_in pending_rows[$];
    cts_pkg::t_result expected_words[$];
    int      errors = 0;
    int      cycles = 0;
    int      burst_left = 0;
    int      gap_left = 0;

    longint sub_s[ROWS_MAX], diag_s[ROWS_MAX], sup_s[ROWS_MAX], rhs_s[ROWS_MAX];
    longint ed[ROWS_MAX], er[ROWS_MAX], wd[ROWS_MAX], wr[ROWS_MAX], wx[ROWS_MAX];
    longint xs[ROWS_MAX], cs[ROWS_MAX];
    int     rows_held = 0;
    bit [1:0] err_flags = 2'b00;
    bit     cyc_mode = MODE_CYC;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned umag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat_m(bit neg, longint unsigned m);
        if (neg) return m > 64'd2147483648 ? VMIN : -longint'(m);
        return m > 64'd2147483647 ? VMAX : longint'(m);
    endfunction

    function automatic longint sat64(longint v);
        return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
    endfunction

    function automatic longint fadd(longint a, longint b);
        return sat64(a + b);
    endfunction

    function automatic longint fsub(longint a, longint b);
        return sat64(a - b);
    endfunction

    function automatic longint fmul(longint a, longint b);
        longint unsigned m;
        m = umag(a) * umag(b);
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return sat_m((a < 0) != (b < 0), m);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint unsigned dm, q;
        if (d == 0) begin
            err_flags[0] = 1'b1;
            return n < 0 ? VMIN : VMAX;
        end
        dm = umag(d);
        q = ((umag(n) << FRAC) + dm / 2) / dm;
        return sat_m((n < 0) != (d < 0), q);
    endfunction

    task automatic thomas_sweep(int n);
        longint m;
        for (int i = 0; i < n; i++) begin
            ed[i] = wd[i];
            er[i] = wr[i];
        end
        for (int i = 1; i < n; i++) begin
            m = fdiv(sub_s[i], ed[i-1]);
            ed[i] = fsub(ed[i], fmul(m, sup_s[i-1]));
            er[i] = fsub(er[i], fmul(m, er[i-1]));
        end
        wx[n-1] = fdiv(er[n-1], ed[n-1]);
        for (int k = n - 2; k >= 0; k--) begin
            wx[k] = fdiv(fsub(er[k], fmul(sup_s[k], wx[k+1])), ed[k]);
        end
    endtask

    task automatic absorb_row(cts_pkg::t_row_in r);
        longint seq[ROWS_MAX+2];
        longint beta, alpha, gamma, num, den, fact;
        int n, cnt;
        cts_pkg::t_result w;
        if (rows_held < ROWS_MAX) begin
            sub_s[rows_held]  = longint'(r.sub_diag);
            diag_s[rows_held] = longint'(r.main_diag);
            sup_s[rows_held]  = longint'(r.super_diag);
            rhs_s[rows_held]  = longint'(r.rhs_value);
            rows_held++;
        end else begin
            err_flags[1] = 1'b1;
        end
        if (r.last_row) begin
            n = rows_held;
            cnt = 0;
            for (int i = 0; i < n; i++) begin
                wd[i] = diag_s[i];
                wr[i] = rhs_s[i];
            end
            if (cyc_mode == MODE_PLAIN) begin
                thomas_sweep(n);
                for (int i = 0; i < n; i++) seq[cnt++] = wx[i];
            end else begin
                beta  = sub_s[0];
                alpha = sup_s[n-1];
                gamma = fsub(0, diag_s[0]);
                wd[0] = fsub(wd[0], gamma);
                wd[n-1] = fsub(wd[n-1], fdiv(fmul(alpha, beta), gamma));
                thomas_sweep(n);
                for (int i = 0; i < n; i++) begin
                    xs[i] = wx[i];
                    wr[i] = 0;
                end
                wr[0] = gamma;
                wr[n-1] = alpha;
                thomas_sweep(n);
                for (int i = 0; i < n; i++) cs[i] = wx[i];
                num = fadd(xs[0], fdiv(fmul(beta, xs[n-1]), gamma));
                den = fadd(fadd(ONE_FX, cs[0]), fdiv(fmul(beta, cs[n-1]), gamma));
                fact = fdiv(num, den);
                for (int i = 0; i < n; i++) xs[i] = fsub(xs[i], fmul(fact, cs[i]));
                seq[cnt++] = xs[n-1];
                for (int i = 0; i < n; i++) seq[cnt++] = xs[i];
                seq[cnt++] = xs[0];
            end
            for (int i = 0; i < cnt; i++) begin
                w.solution   = seq[i][31:0];
                w.last_value = (i == cnt - 1);
                w.status     = err_flags[1] ? cts_pkg::STATUS_ROWS :
                               (err_flags[0] ? cts_pkg::STATUS_ZERO : cts_pkg::STATUS_OK);
                expected_words.push_back(w);
            end
            rows_held = 0;
            err_flags = 2'b00;
        end
    endtask

    // driver: hold the word while busy, advance on acceptance, idle in gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                absorb_row(pending_rows.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_rows.size() > 0) begin
                start <= 1'b1;
                i_row <= pending_rows[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                if (o_result.solution !== expected_words[0].solution ||
                    o_result.last_value !== expected_words[0].last_value ||
                    o_result.status !== expected_words[0].status) begin
                    $display({"%0t: mismatch, expected sol %h last %b st %0d,",
                              " actual sol %h last %b st %0d"},
                             $time, expected_words[0].solution, expected_words[0].last_value,
                             expected_words[0].status, o_result.solution,
                             o_result.last_value, o_result.status);
                    errors++;
                end
                void'(expected_words.pop_front());
            end
        end
    end

    function automatic cts_pkg::t_fx rnd_span(int span);
        return cts_pkg::t_fx'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic push_row(cts_pkg::t_fx s, cts_pkg::t_fx d, cts_pkg::t_fx u,
                            cts_pkg::t_fx r, bit last);
        cts_pkg::t_row_in w;
        w.sub_diag = s;
        w.main_diag = d;
        w.super_diag = u;
        w.rhs_value = r;
        w.last_row = last;
        pending_rows.push_back(w);
    endtask

    task automatic push_system(int n, int kind);
        cts_pkg::t_fx s, u, d;
        longint m;
        for (int i = 0; i < n; i++) begin
            if (kind == 1) begin
                push_row($urandom, $urandom, $urandom, $urandom, i == n - 1);
            end else begin
                s = rnd_span(1 << 17);
                u = rnd_span(1 << 17);
                m = umag(s) + umag(u) + $urandom_range(1 << 12, 1 << 18);
                d = $urandom_range(0, 1) ? cts_pkg::t_fx'(m) : cts_pkg::t_fx'(-m);
                if (kind == 2 && $urandom_range(0, 2) == 0) d = '0;
                push_row(s, d, u, rnd_span(1 << 21), i == n - 1);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_rows.size() > 0 || start || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_mode(bit m);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        cyc_mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int total;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_system(1, 0);
        push_system(3, 0);
        push_row(32'sh0001_0000, '0, 32'sh0000_8000, 32'sh0002_0000, 1'b0);
        push_row(32'sh0000_4000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
        push_row(cts_pkg::FX_MAX, cts_pkg::FX_MIN, cts_pkg::FX_MAX, cts_pkg::FX_MIN, 1'b0);
        push_row(cts_pkg::FX_MIN, cts_pkg::FX_MAX, cts_pkg::FX_MIN, cts_pkg::FX_MAX, 1'b1);
        set_mode(MODE_PLAIN);
        push_system(1, 0);
        push_system(4, 0);
        push_row(32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0003_0000, 1'b0);
        push_row(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, '0, 1'b0);
        push_row(cts_pkg::FX_MIN, cts_pkg::FX_MAX, cts_pkg::FX_MAX, cts_pkg::FX_MIN, 1'b1);
        push_system(1, 1);
        set_mode(MODE_CYC);
        push_system(ROWS_MAX + 2, 0);
        set_mode(MODE_PLAIN);
        push_system(ROWS_MAX + 1, 2);

        total = 0;
        while (total < 185) begin
            if ($urandom_range(0, 5) == 0) set_mode($urandom_range(0, 1));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1: push_system(n, 1);
                2: push_system(n, 2);
                default: push_system(n, 0);
            endcase
            total += n;
        end
        set_mode(MODE_CYC);
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cts_pkg.sv
hdl/cts_ram.sv
hdl/cts_div.sv
hdl/cts_dp.sv
hdl/cts_ctrl.sv
hdl/cyclic_tridiagonal_solver.sv
dv/tb_cyclic_tridiagonal_solver.sv
